FILE: design/tccc_pkg.sv
// Shared constants and types for the text console cursor control block.
`timescale 1ns / 1ps

package tccc_pkg;

  // field widths
  localparam int CHAR_W = 8;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 9;
  localparam int ADDR_W = 25;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 14;
  localparam int IDX_W  = 2;
  localparam int PIX_W  = 13;
  localparam int NCOL_W = COL_W + 1;
  localparam int NROW_W = ROW_W + 1;
  localparam int TDATA_W = 56;

  localparam logic [PIX_W-1:0]  MAX_PIXELS = 13'd4096;
  localparam logic [NCOL_W-1:0] MAX_COLS   = 11'd1024;
  localparam logic [NROW_W-1:0] MAX_ROWS   = 10'd512;

  localparam int DEF_CELL_W = 6;
  localparam int DEF_CELL_H = 9;

  // result ops
  localparam logic [OP_W-1:0] OP_GLYPH        = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR_CELL   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCROLL       = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_SCREEN = 2'd3;

  // input commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_HOME  = 1'b1;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_STRIDE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] glyph;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } res_t;

endpackage

FILE: design/text_console_cursor_control.sv
// Text console cursor control: cursor tracking and cell command generation.
`timescale 1ns / 1ps

// Keeps a text cursor over a grid of CELL_W x CELL_H pixel cells and turns each
// character (or home-and-clear command) into zero, one or two cell commands,
// each with its top-left pixel address. Items enter a one-deep input register;
// the cursor logic and a single row-address multiplier sit between it and a
// two-entry result register. The next item leaves the input register once no
// result is held, or as the last held result is taken; a glyph that wraps into a
// scroll makes two results, which drain one transaction per cycle while m_tready
// is high. Column and row counts and the row pitch are derived when a register is
// written and are in effect on the next cycle.
module text_console_cursor_control
  import tccc_pkg::*;
#(
  parameter int CELL_W = DEF_CELL_W,
  parameter int CELL_H = DEF_CELL_H
) (
  input  logic               clk,
  input  logic               rst,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic               s_tuser,   // [0] command
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [9:0] cell_column, [18:10] cell_row,
                                        // [26:19] glyph_code, [51:27] cell_address
  output logic [OP_W-1:0]    m_tuser,   // [1:0] op
  output logic               m_tlast
);

  // floor division by reciprocal multiply; exact for 13-bit inputs and cells up to 32
  localparam int DIV_SH  = PIX_W + 5;
  localparam int W_RECIP = ((1 << DIV_SH) + CELL_W - 1) / CELL_W;
  localparam int H_RECIP = ((1 << DIV_SH) + CELL_H - 1) / CELL_H;

  // derived configuration
  logic [NCOL_W-1:0] grid_cols;
  logic [NROW_W-1:0] grid_rows;
  logic [ADDR_W-1:0] row_stride;
  logic [PIX_W-1:0]  pix_sat;
  logic [31:0]       cols_prod;
  logic [31:0]       rows_prod;
  logic [PIX_W-1:0]  cols_q;
  logic [PIX_W-1:0]  rows_q;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign pix_sat   = (cfg_data[PIX_W-1:0] > MAX_PIXELS) ? MAX_PIXELS : cfg_data[PIX_W-1:0];
  assign cols_prod = 32'(pix_sat) * 32'(W_RECIP);
  assign rows_prod = 32'(pix_sat) * 32'(H_RECIP);
  assign cols_q    = PIX_W'(cols_prod >> DIV_SH);
  assign rows_q    = PIX_W'(rows_prod >> DIV_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols  <= '0;
      grid_rows  <= '0;
      row_stride <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:
          grid_cols <= (cols_q > PIX_W'(MAX_COLS)) ? MAX_COLS : cols_q[NCOL_W-1:0];
        REG_HEIGHT:
          grid_rows <= (rows_q > PIX_W'(MAX_ROWS)) ? MAX_ROWS : rows_q[NROW_W-1:0];
        REG_STRIDE:
          row_stride <= ADDR_W'(cfg_data * CELL_H);
        default: ;
      endcase
    end
  end

  // input register
  logic              v1;
  logic              cmd1;
  logic [CHAR_W-1:0] ch1;
  logic              fire;

  assign s_tready = !v1 || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      v1 <= 1'b1;
    end else if (fire) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd1 <= s_tuser;
      ch1  <= s_tdata;
    end
  end

  // cursor and command logic
  logic [COL_W-1:0]  cursor_column, cursor_column_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [COL_W-1:0]  c_sat;
  logic [ROW_W-1:0]  r_sat;
  logic [NCOL_W-1:0] col_inc;
  logic [NROW_W-1:0] row_inc;
  logic              grid_ok;
  logic              wrap;
  logic              at_bottom;
  logic [ADDR_W-1:0] row_base;
  logic [COL_W-1:0]  addr_col;
  logic [ADDR_W-1:0] col_off;
  logic [1:0]        n_res;
  res_t              res0, res1;

  assign grid_ok  = (grid_cols != '0) && (grid_rows != '0);
  assign c_sat    = ({1'b0, cursor_column} >= grid_cols) ? COL_W'(grid_cols - 1'b1)
                                                         : cursor_column;
  assign r_sat    = ({1'b0, cursor_row} >= grid_rows) ? ROW_W'(grid_rows - 1'b1)
                                                      : cursor_row;
  assign col_inc  = {1'b0, c_sat} + 1'b1;
  assign row_inc  = {1'b0, r_sat} + 1'b1;
  assign wrap     = col_inc >= grid_cols;
  assign at_bottom = !(row_inc < grid_rows);
  assign row_base = ADDR_W'(r_sat * row_stride);
  assign addr_col = (ch1 == CH_BS) ? c_sat - 1'b1 : (ch1 == CH_LF) ? '0 : c_sat;
  assign col_off  = ADDR_W'(addr_col * CELL_W);

  always_comb begin
    cursor_column_next = c_sat;
    cursor_row_next    = r_sat;
    n_res              = 2'd0;
    res0.op    = OP_GLYPH;
    res0.col   = addr_col;
    res0.row   = r_sat;
    res0.glyph = '0;
    res0.addr  = row_base + col_off;
    res0.last  = 1'b0;
    // the second result only ever scrolls from the last row
    res1.op    = OP_SCROLL;
    res1.col   = '0;
    res1.row   = r_sat;
    res1.glyph = '0;
    res1.addr  = row_base;
    res1.last  = 1'b1;
    priority if (!grid_ok) begin
      cursor_column_next = cursor_column;
      cursor_row_next    = cursor_row;
    end else if (cmd1 == CMD_HOME) begin
      cursor_column_next = '0;
      cursor_row_next    = '0;
      n_res     = 2'd1;
      res0.op   = OP_CLEAR_SCREEN;
      res0.col  = '0;
      res0.row  = '0;
      res0.addr = '0;
    end else if (ch1 == CH_CR) begin
      n_res = 2'd0;
    end else if (ch1 == CH_BS) begin
      if (c_sat != '0) begin
        cursor_column_next = addr_col;
        n_res   = 2'd1;
        res0.op = OP_CLEAR_CELL;
      end
    end else if (ch1 == CH_LF) begin
      cursor_column_next = '0;
      if (at_bottom) begin
        n_res   = 2'd1;
        res0.op = OP_SCROLL;
      end else begin
        cursor_row_next = row_inc[ROW_W-1:0];
      end
    end else begin
      res0.glyph = ch1;
      n_res      = 2'd1;
      if (wrap) begin
        cursor_column_next = '0;
        if (at_bottom) begin
          n_res = 2'd2;
        end else begin
          cursor_row_next = row_inc[ROW_W-1:0];
        end
      end else begin
        cursor_column_next = col_inc[COL_W-1:0];
      end
    end
    res0.last = (n_res == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (fire) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

  // result register pair: o0 is on the port, o1 holds a pending scroll
  logic out_valid;
  logic has_second;
  logic out_take;
  res_t o0, o1;

  assign out_take = m_tvalid && m_tready;
  assign fire     = v1 && (!out_valid || (out_take && !has_second));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      has_second <= 1'b0;
    end else if (fire && (n_res != 2'd0)) begin
      out_valid  <= 1'b1;
      has_second <= (n_res == 2'd2);
    end else if (out_take) begin
      if (has_second) begin
        has_second <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (n_res != 2'd0)) begin
      o0 <= res0;
      o1 <= res1;
    end else if (out_take && has_second) begin
      o0 <= o1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = o0.op;
  assign m_tlast  = o0.last;
  assign m_tdata  = {4'b0, o0.addr, o0.glyph, o0.row, o0.col};

`ifndef ASSERT_OFF
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    has_second |-> (m_tvalid && !m_tlast))
    else $error("pending second result without a first one ahead of it");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (fire && grid_ok && !cfg_we) |=>
      (({1'b0, cursor_column} < grid_cols) && ({1'b0, cursor_row} < grid_rows)))
    else $error("cursor left the grid after an item");

  a_clear_screen_home: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == OP_CLEAR_SCREEN)) |-> (o0.addr == '0 && o0.row == '0))
    else $error("clear screen result not at origin");

  a_no_fire_while_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && (n_res == 2'd2)) |=> (has_second && m_tvalid))
    else $error("two-result item did not load both result slots");
`endif

endmodule

FILE: bench/tb_text_console_cursor_control.sv
// Self-checking testbench for the text console cursor control block.
`timescale 1ns / 1ps

module tb_text_console_cursor_control;
  import tccc_pkg::*;

  localparam int CELL_W        = DEF_CELL_W;
  localparam int CELL_H        = DEF_CELL_H;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  // index 3 is not a register; writes to it must be ignored
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [CHAR_W-1:0]  s_tdata   = '0;  // [7:0] char_code
  logic               s_tuser   = 1'b0; // [0] command
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [TDATA_W-1:0] m_tdata;         // [9:0] col, [18:10] row, [26:19] glyph, [51:27] addr
  logic [OP_W-1:0]    m_tuser;         // [1:0] op
  logic               m_tlast;

  text_console_cursor_control #(
    .CELL_W(CELL_W),
    .CELL_H(CELL_H)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // console state as the bench sees it
  logic [PIX_W-1:0] width_px  = '0;
  logic [PIX_W-1:0] height_px = '0;
  logic [CFG_W-1:0] stride_px = '0;
  logic [COL_W-1:0] cur_col   = '0;
  logic [ROW_W-1:0] cur_row   = '0;

  res_t expected_cmds[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_rx       = 1'b0;
  int unsigned err_count     = 0;
  int unsigned items_sent    = 0;
  int unsigned cmds_seen     = 0;
  int unsigned reg_writes    = 0;

  function automatic void queue_cmd(input logic [OP_W-1:0] op, input int unsigned col,
                                    input int unsigned row, input logic [CHAR_W-1:0] glyph);
    res_t r;
    longint unsigned a;
    a       = longint'(row) * CELL_H * stride_px + longint'(col) * CELL_W;
    r.op    = op;
    r.col   = col[COL_W-1:0];
    r.row   = row[ROW_W-1:0];
    r.glyph = glyph;
    r.addr  = a[ADDR_W-1:0];
    r.last  = 1'b0;
    expected_cmds.push_back(r);
  endfunction

  // moves to column 0 of the next row, scrolling on the last row
  function automatic int line_feed(input int unsigned nrows);
    cur_col = '0;
    if (32'(cur_row) + 1 < nrows) begin
      cur_row++;
      return 0;
    end
    cur_row = ROW_W'(nrows - 1);
    queue_cmd(OP_SCROLL, 0, nrows - 1, '0);
    return 1;
  endfunction

  function automatic void console_predict(input logic cmd, input logic [CHAR_W-1:0] ch);
    int unsigned ncols, nrows;
    int nres;
    ncols = ((width_px > MAX_PIXELS) ? MAX_PIXELS : width_px) / CELL_W;
    nrows = ((height_px > MAX_PIXELS) ? MAX_PIXELS : height_px) / CELL_H;
    if (ncols > MAX_COLS) ncols = 32'(MAX_COLS);
    if (nrows > MAX_ROWS) nrows = 32'(MAX_ROWS);
    if (ncols == 0 || nrows == 0) return;
    if (cur_col >= ncols) cur_col = COL_W'(ncols - 1);
    if (cur_row >= nrows) cur_row = ROW_W'(nrows - 1);
    nres = 0;
    if (cmd == CMD_HOME) begin
      cur_col = '0;
      cur_row = '0;
      queue_cmd(OP_CLEAR_SCREEN, 0, 0, '0);
      nres = 1;
    end else if (ch == CH_CR) begin
      nres = 0;
    end else if (ch == CH_BS) begin
      if (cur_col != 0) begin
        cur_col--;
        queue_cmd(OP_CLEAR_CELL, 32'(cur_col), 32'(cur_row), '0);
        nres = 1;
      end
    end else if (ch == CH_LF) begin
      nres = line_feed(nrows);
    end else begin
      queue_cmd(OP_GLYPH, 32'(cur_col), 32'(cur_row), ch);
      nres = 1;
      // compare before the increment so a full-width row cannot wrap the counter
      if (32'(cur_col) + 1 >= ncols) nres += line_feed(nrows);
      else cur_col++;
    end
    if (nres > 0) expected_cmds[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_WIDTH:  width_px  = data[PIX_W-1:0];
      REG_HEIGHT: height_px = data[PIX_W-1:0];
      REG_STRIDE: stride_px = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned s);
    set_reg(REG_WIDTH, CFG_W'(w));
    set_reg(REG_HEIGHT, CFG_W'(h));
    set_reg(REG_STRIDE, CFG_W'(s));
  endtask

  task automatic send_char(input logic cmd, input logic [CHAR_W-1:0] ch);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    console_predict(cmd, ch);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop valid, wait for every expected command, then let in-flight work finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void pick_item(input bit glyph_heavy, output logic cmd,
                                    output logic [CHAR_W-1:0] ch);
    int unsigned roll;
    roll = $urandom_range(99);
    cmd  = CMD_WRITE;
    ch   = CHAR_W'($urandom_range(255));
    if (glyph_heavy) begin
      if (roll < 3) ch = CH_BS;
      else if (roll < 5) ch = CH_CR;
    end else if (roll < 3) begin
      cmd = CMD_HOME;
    end else if (roll < 15) begin
      ch = CH_LF;
    end else if (roll < 25) begin
      ch = CH_BS;
    end else if (roll < 30) begin
      ch = CH_CR;
    end
  endfunction

  task automatic run_text(input int n, input bit glyph_heavy);
    logic             cmd;
    logic [CHAR_W-1:0] ch;
    repeat (n) begin
      pick_item(glyph_heavy, cmd, ch);
      send_char(cmd, ch);
    end
    settle();
  endtask

  // ------------------------------------------------------- receiver / checker

  always @(posedge clk)
    m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);

  task automatic report(input string what, input res_t want, input res_t got);
    string exp_s;
    string got_s;
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      exp_s = $sformatf("op=%0d col=%0d row=%0d glyph=%02h addr=%07h last=%0b",
                        want.op, want.col, want.row, want.glyph, want.addr, want.last);
      got_s = $sformatf("op=%0d col=%0d row=%0d glyph=%02h addr=%07h last=%0b",
                        got.op, got.col, got.row, got.glyph, got.addr, got.last);
      $display("%0t %s: exp %s | got %s", $realtime, what, exp_s, got_s);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.op    = m_tuser;
      got.col   = m_tdata[9:0];
      got.row   = m_tdata[18:10];
      got.glyph = m_tdata[26:19];
      got.addr  = m_tdata[51:27];
      got.last  = m_tlast;
      cmds_seen++;
      if (expected_cmds.size() == 0) begin
        report("unexpected transaction", '0, got);
      end else begin
        want = expected_cmds.pop_front();
        if (got.op !== want.op || got.col !== want.col || got.row !== want.row ||
            got.glyph !== want.glyph || got.addr !== want.addr || got.last !== want.last)
          report("mismatch", want, got);
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // registers reset to zero, so nothing may come out; also zero-width and zero-height grids
  task automatic test_empty_grid();
    send_char(CMD_WRITE, 8'h41);
    send_char(CMD_HOME, 8'h00);
    send_char(CMD_WRITE, CH_LF);
    settle();
    configure(5, 4096, 100);
    send_char(CMD_WRITE, 8'h42);
    send_char(CMD_HOME, 8'hFF);
    settle();
    configure(4096, 8, 100);
    send_char(CMD_WRITE, 8'h43);
    send_char(CMD_WRITE, CH_LF);
    settle();
  endtask

  // 3 x 2 grid: every op, edge bytes, backspace at column 0, wrap with and without scroll
  task automatic test_directed();
    configure(18, 18, 100);
    set_reg(REG_NONE, 14'h3FFF);
    send_char(CMD_HOME, 8'h55);
    send_char(CMD_WRITE, 8'h41);
    send_char(CMD_WRITE, CH_CR);
    send_char(CMD_WRITE, CH_BS);
    send_char(CMD_WRITE, CH_BS);
    send_char(CMD_WRITE, 8'h00);
    send_char(CMD_WRITE, 8'hFF);
    send_char(CMD_WRITE, 8'h44);   // wraps to row 1
    send_char(CMD_WRITE, CH_LF);   // last row: scroll
    send_char(CMD_WRITE, 8'h45);
    send_char(CMD_WRITE, 8'h46);
    send_char(CMD_WRITE, 8'h47);   // wraps on last row: glyph then scroll
    send_char(CMD_WRITE, CH_BS);
    send_char(CMD_WRITE, 8'h7F);
    send_char(CMD_WRITE, 8'h80);
    send_char(CMD_HOME, 8'hAA);
    settle();
  endtask

  task automatic test_random_grids();
    configure(18, 27, 100);
    run_text(200, 1'b0);
    configure(4096, 4096, 16383);
    run_text(150, 1'b0);
    // one column, tall screen: every glyph moves a row, addresses wrap past 25 bits
    configure(6, 8191, 16383);
    run_text(300, 1'b1);
    send_idle_pct = 54;
    recv_idle_pct = 8;
    // shrinking grid pulls the cursor back inside
    configure(13, 20, 0);
    run_text(150, 1'b0);
    configure(16383, 45, 7);
    run_text(100, 1'b0);
    configure(60, 45, 7);
    run_text(100, 1'b0);
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(6, 30, 50);
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    run_text(40, 1'b1);
    configure(60, 45, 7);
    run_text(60, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 8;
    recv_idle_pct = 54;
    test_empty_grid();
    test_directed();
    test_random_grids();
    test_output_stall();
    $display("Sent %0d items, checked %0d cell commands, %0d register writes.",
             items_sent, cmds_seen, reg_writes);
    $display("Grids: empty, 3x2, 3x3, full size, one column tall, shrinking; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for transactions");
    $display("Regression FAIL");
    $finish;
  end

endmodule
